// ===== rtl/core/shcp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shcp_pkg
// Types, constants and helper functions used by the serial hex command
// parser, including the item types carried on its stream channels.
// ----------------------------------------------------------------------------
package shcp_pkg;

	localparam int unsigned LINE_LIMIT_DEF    = 512;
	localparam int unsigned PAYLOAD_LIMIT_DEF = 240;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	// command words, first character in the top byte
	localparam logic [31:0] WORD_PING = 32'h50494E47;
	localparam logic [31:0] WORD_INFO = 32'h494E464F;
	localparam logic [23:0] WORD_TX   = 24'h545820;

	typedef enum logic {
		OP_CHAR = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		KIND_PONG     = 3'd0,
		KIND_INFO     = 3'd1,
		KIND_TX       = 3'd2,
		KIND_UNKNOWN  = 3'd3,
		KIND_HEX_ERR  = 3'd4,
		KIND_TOO_LONG = 3'd5,
		KIND_READ     = 3'd6
	} result_kind_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] char_in;
		logic [7:0] read_index;
	} in_item_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic [7:0]   payload_length;
		logic [7:0]   read_data;
	} out_item_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} nibble_t;

	function automatic nibble_t hex_nibble(input logic [7:0] c);
		nibble_t n;
		n.ok  = 1'b1;
		n.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			n.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			n.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			n.val = 4'(c - 8'h37);
		end else begin
			n.ok = 1'b0;
		end
		return n;
	endfunction

	function automatic logic [7:0] word4_char(input logic [31:0] w, input logic [1:0] p);
		logic [7:0] c;
		case (p)
			2'd0: c = w[31:24];
			2'd1: c = w[23:16];
			2'd2: c = w[15:8];
			default: c = w[7:0];
		endcase
		return c;
	endfunction

	function automatic logic [7:0] tx_char(input logic [1:0] p);
		logic [7:0] c;
		case (p)
			2'd0: c = WORD_TX[23:16];
			2'd1: c = WORD_TX[15:8];
			default: c = WORD_TX[7:0];
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/shcp_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shcp_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface shcp_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/serial_hex_command_parser_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_hex_command_parser_unit
// Line assembler and command classifier for serial text with hex payloads.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one beat per serial character (op = char) or per payload
//          byte read (op = read, read_index selects the byte).
//   out_ch carries at most one result beat per input beat: pong, info,
//          tx ready with the byte count, unknown command, hex error, line
//          too long, or read data.
//   The result of each input beat, if any, is in the output register the
//   cycle after the beat is accepted. One beat is taken every cycle while
//   in_ch.ready is high; the single-port payload memory is read or written once per beat.
//   If out_ch stalls with a result pending, in_ch.ready drops until the
//   result is taken, so the block holds at most one finished result.
//   Reset clears the line state and the output valid; the payload memory is
//   not cleared and only bytes below the last reported length are meaningful.
//   Hex digits are decoded into the payload memory as they arrive.
// ----------------------------------------------------------------------------
module serial_hex_command_parser_unit
	import shcp_pkg::*;
#(
	parameter int unsigned LINE_LIMIT    = LINE_LIMIT_DEF,
	parameter int unsigned PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	shcp_stream_if.sink        in_ch,
	shcp_stream_if.source      out_ch
);

	localparam int unsigned LW   = $clog2(LINE_LIMIT);
	localparam int unsigned NLIM = 2 * PAYLOAD_LIMIT;
	localparam int unsigned NW   = $clog2(NLIM + 2);
	localparam int unsigned AW   = (PAYLOAD_LIMIT > 1) ? $clog2(PAYLOAD_LIMIT) : 1;

	// line state
	logic [LW-1:0] line_q, line_d;
	logic          discard_q, discard_d;
	logic          zero_q, zero_d;
	logic          ping_q, ping_d;
	logic          info_q, info_d;
	logic          tx_q, tx_d;
	logic [NW-1:0] nib_q, nib_d;
	logic [3:0]    upper_q, upper_d;
	logic          hexerr_q, hexerr_d;

	// result register
	logic          out_valid_q;
	result_kind_t  kind_q;
	logic [7:0]    len_q;
	logic          rd_hit_q;
	logic [7:0]    rd_data_q;

	logic [7:0] mem [PAYLOAD_LIMIT];

	in_item_t     it;
	logic         in_acc;
	logic         has_res;
	result_kind_t res_kind;
	logic [7:0]   res_len;
	logic         wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]   wr_data;
	logic         rd_in_range;
	nibble_t      hn;
	logic         text_ge4, text_ge3;

	assign it          = in_ch.data;
	assign in_ch.ready = ~out_valid_q | out_ch.ready;
	assign in_acc      = in_ch.valid & in_ch.ready;
	assign rd_in_range = it.read_index < 8'(PAYLOAD_LIMIT);
	assign hn          = hex_nibble(it.char_in);
	assign text_ge4    = zero_q | (line_q >= LW'(4));
	assign text_ge3    = zero_q | (line_q >= LW'(3));

	always_comb begin
		line_d    = line_q;
		discard_d = discard_q;
		zero_d    = zero_q;
		ping_d    = ping_q;
		info_d    = info_q;
		tx_d      = tx_q;
		nib_d     = nib_q;
		upper_d   = upper_q;
		hexerr_d  = hexerr_q;
		has_res   = 1'b0;
		res_kind  = KIND_READ;
		res_len   = 8'd0;
		wr_en     = 1'b0;
		wr_addr   = AW'(nib_q >> 1);
		wr_data   = {upper_q, hn.val};

		if (it.op == OP_READ) begin
			has_res  = 1'b1;
			res_kind = KIND_READ;
		end else if (it.char_in == CHAR_CR) begin
			has_res = 1'b0;
		end else if (it.char_in == CHAR_LF || (!discard_q && line_q >= LW'(LINE_LIMIT - 1))) begin
			// end of line or overflow: classify or flag, then start a new line
			if (it.char_in != CHAR_LF) begin
				has_res   = 1'b1;
				res_kind  = KIND_TOO_LONG;
				discard_d = 1'b1;
			end else if (discard_q) begin
				discard_d = 1'b0;
			end else if (line_q != '0) begin
				has_res = 1'b1;
				if (ping_q && text_ge4) begin
					res_kind = KIND_PONG;
				end else if (info_q && text_ge4) begin
					res_kind = KIND_INFO;
				end else if (!(tx_q && text_ge3)) begin
					res_kind = KIND_UNKNOWN;
				end else if (hexerr_q || nib_q == '0 || nib_q[0] || nib_q > NW'(NLIM)) begin
					res_kind = KIND_HEX_ERR;
				end else begin
					res_kind = KIND_TX;
					res_len  = 8'(nib_q >> 1);
				end
			end
			line_d   = '0;
			zero_d   = 1'b0;
			ping_d   = 1'b1;
			info_d   = 1'b1;
			tx_d     = 1'b1;
			nib_d    = '0;
			upper_d  = 4'd0;
			hexerr_d = 1'b0;
		end else if (!discard_q) begin
			if (!zero_q) begin
				if (it.char_in == CHAR_NUL) begin
					zero_d = 1'b1;
					if (line_q < LW'(4)) begin
						ping_d = 1'b0;
						info_d = 1'b0;
					end
					if (line_q < LW'(3)) begin
						tx_d = 1'b0;
					end
				end else begin
					if (line_q >= LW'(4) || it.char_in != word4_char(WORD_PING, line_q[1:0])) begin
						ping_d = 1'b0;
					end
					if (line_q >= LW'(4) || it.char_in != word4_char(WORD_INFO, line_q[1:0])) begin
						info_d = 1'b0;
					end
					if (line_q < LW'(3)) begin
						if (it.char_in != tx_char(line_q[1:0])) begin
							tx_d = 1'b0;
						end
					end else if (tx_q) begin
						// hex digit after the command prefix
						if (!hn.ok) begin
							hexerr_d = 1'b1;
						end else if (!hexerr_q && nib_q < NW'(NLIM)) begin
							if (!nib_q[0]) begin
								upper_d = hn.val;
							end else begin
								wr_en = 1'b1;
							end
						end
						if (nib_q <= NW'(NLIM)) begin
							nib_d = nib_q + NW'(1);
						end
					end
				end
			end
			line_d = line_q + LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q    <= '0;
			discard_q <= 1'b0;
			zero_q    <= 1'b0;
			ping_q    <= 1'b1;
			info_q    <= 1'b1;
			tx_q      <= 1'b1;
			nib_q     <= '0;
			upper_q   <= 4'd0;
			hexerr_q  <= 1'b0;
		end else if (in_acc) begin
			line_q    <= line_d;
			discard_q <= discard_d;
			zero_q    <= zero_d;
			ping_q    <= ping_d;
			info_q    <= info_d;
			tx_q      <= tx_d;
			nib_q     <= nib_d;
			upper_q   <= upper_d;
			hexerr_q  <= hexerr_d;
		end
	end

	// payload memory: one write or one registered read per beat
	always_ff @(posedge clk) begin
		if (in_acc && wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (in_acc && it.op == OP_READ && rd_in_range) begin
			rd_data_q <= mem[it.read_index[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (in_acc & has_res) | (out_valid_q & ~out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_res) begin
			kind_q   <= res_kind;
			len_q    <= res_len;
			rd_hit_q <= (it.op == OP_READ) & rd_in_range;
		end
	end

	assign out_ch.valid               = out_valid_q;
	assign out_ch.data.result_kind    = kind_q;
	assign out_ch.data.payload_length = len_q;
	assign out_ch.data.read_data      = rd_hit_q ? rd_data_q : 8'd0;

endmodule
`default_nettype wire
